[design/etba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-truncated box average: shared package
// Pixel and result types, size defaults and divider control.
// ----------------------------------------------------------------------------
package etba_pkg;

  localparam int MAX_SIDE_DEF     = 1024;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int FIELD_W          = 16;
  localparam int POS_W            = 10;
  localparam int CFG_W            = 11;
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [FIELD_W-1:0] in_red;
    logic [FIELD_W-1:0] in_green;
    logic [FIELD_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic [FIELD_W-1:0] avg_red;
    logic [FIELD_W-1:0] avg_green;
    logic [FIELD_W-1:0] avg_blue;
    logic               run_end;
  } pix_out_t;

  typedef struct packed {
    logic       en;
    logic [3:0] k;
  } div_ctl_t;

endpackage

[design/etba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-truncated box average: line store RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module etba_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/etba_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-truncated box average: small-constant divider
// Divides three channel sums by a window count of 1, 2, 3, 4, 6 or 9
// through a registered reciprocal product and one correction step.
// ----------------------------------------------------------------------------
module etba_div #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                                clk_i,
  input  etba_pkg::div_ctl_t                  ctl_i,
  input  logic [2:0][CHANNEL_BITS+3:0]        sum_i,
  output logic [2:0][CHANNEL_BITS-1:0]        avg_o
);
  import etba_pkg::*;

  localparam int SW = CHANNEL_BITS + 4;
  localparam longint unsigned ONE = 64'd1 << SW;
  localparam logic [SW:0] R1 = (SW+1)'(ONE);
  localparam logic [SW:0] R2 = (SW+1)'(ONE / 2);
  localparam logic [SW:0] R3 = (SW+1)'(ONE / 3);
  localparam logic [SW:0] R4 = (SW+1)'(ONE / 4);
  localparam logic [SW:0] R6 = (SW+1)'(ONE / 6);
  localparam logic [SW:0] R9 = (SW+1)'(ONE / 9);

  logic [SW:0]        recip;
  logic [2:0][2*SW:0] prod_q;
  logic [2:0][SW-1:0] x_q;
  logic [3:0]         k_q;

  always_comb begin
    case (ctl_i.k)
      4'd2:    recip = R2;
      4'd3:    recip = R3;
      4'd4:    recip = R4;
      4'd6:    recip = R6;
      4'd9:    recip = R9;
      default: recip = R1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= (2*SW+1)'(sum_i[ch]) * (2*SW+1)'(recip);
        x_q[ch]    <= sum_i[ch];
      end
      k_q <= ctl_i.k;
    end
  end

  always_comb begin
    logic [SW:0]   q;
    logic [SW+4:0] qk;
    for (int ch = 0; ch < 3; ch++) begin
      q  = prod_q[ch][2*SW:SW];
      qk = (SW+5)'(q) * (SW+5)'(k_q);
      if ((SW+5)'(x_q[ch]) >= qk + (SW+5)'(k_q)) begin
        q = q + 1'b1;
      end
      avg_o[ch] = q[CHANNEL_BITS-1:0];
    end
  end

endmodule

[design/edge_truncated_box_average_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-truncated box average: top level
// 3x3 mean over a square RGB image with windows cut at the image border.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o / in_pixel_i, one raster-order
//   pixel per request. Output channel: out_valid_o / out_stall_i /
//   out_pixel_o, one averaged pixel per request with its row and column;
//   run_end marks the last result caused by an input pixel.
//   cfg_we_i writes the image side (1..MAX_SIDE) and restarts the frame.
//   A pixel passes through the read of both line stores and the write-back,
//   then through sum, reciprocal product and correction for each result.
//   A pixel with no result returns to idle after the write-back; the input
//   stays stalled until every result of a pixel has been taken. The line
//   store read-modify-write and the shared divider set this pacing.
//   A finished result sits in the output register while the next pixel is
//   taken; a stall holds the divider until that register frees.
//   Reset clears counters, the column window and sets the side to 1024;
//   the line stores need no clearing.
// ----------------------------------------------------------------------------
module edge_truncated_box_average_top #(
  parameter int MAX_SIDE     = etba_pkg::MAX_SIDE_DEF,
  parameter int CHANNEL_BITS = etba_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  etba_pkg::pix_in_t             in_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output etba_pkg::pix_out_t            out_pixel_o,
  input  logic                          cfg_we_i,
  input  logic [etba_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import etba_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);
  localparam int NW = ($clog2(MAX_SIDE + 1) > CFG_W) ? $clog2(MAX_SIDE + 1) : CFG_W;
  localparam int CB = CHANNEL_BITS;
  localparam int SW = CB + 4;
  localparam int PW = 3 * CB;

  typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_SUM, ST_MUL, ST_OUT} state_e;

  state_e              st_q;
  logic [CFG_W-1:0]    size_q;
  logic [CW-1:0]       row_q, col_q, rr_q, cc_q;
  logic [5:0][PW-1:0]  cw_q;
  logic [8:0]          pend_q;
  logic                out_valid_q;
  pix_out_t            out_q;
  logic [PW-1:0]       cur_q;
  logic [2:0][2:0][PW-1:0] g_q;
  logic [2:0][SW-1:0]  sum_q;
  logic [3:0]          k_q;
  logic [CW-1:0]       orow_q, ocol_q;
  logic                last_q;

  logic [NW-1:0]       side, sz;
  logic                accept, slot_free, lastr, lastc;
  logic [CW-1:0]       eff_r, eff_c;
  logic [PW-1:0]       newer_rd, older_rd, cur_in;
  logic [2:0]          rv, cv;
  logic [8:0]          pend_new, pend_clr;
  logic [1:0]          sel_rs, sel_cs;
  logic [2:0][SW-1:0]  sum_d;
  logic [3:0]          k_d;
  logic [NW-1:0]       c_inc, r_inc;
  div_ctl_t            div_ctl;
  logic [2:0][CB-1:0]  avg;

  assign sz   = NW'(size_q);
  assign side = (sz == '0) ? NW'(1) : ((sz > NW'(MAX_SIDE)) ? NW'(MAX_SIDE) : sz);

  assign in_stall_o = (st_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign eff_r = (NW'(row_q) >= side || NW'(col_q) >= side) ? '0 : row_q;
  assign eff_c = (NW'(row_q) >= side || NW'(col_q) >= side) ? '0 : col_q;

  assign cur_in = {in_pixel_i.in_red[CB-1:0], in_pixel_i.in_green[CB-1:0],
                   in_pixel_i.in_blue[CB-1:0]};

  etba_ram #(.WIDTH(PW), .DEPTH(MAX_SIDE)) u_newer (
    .clk_i   (clk_i),
    .we_i    (st_q == ST_LOAD),
    .waddr_i (cc_q),
    .wdata_i (cur_q),
    .raddr_i (eff_c),
    .rdata_o (newer_rd)
  );

  etba_ram #(.WIDTH(PW), .DEPTH(MAX_SIDE)) u_older (
    .clk_i   (clk_i),
    .we_i    (st_q == ST_LOAD),
    .waddr_i (cc_q),
    .wdata_i (newer_rd),
    .raddr_i (eff_c),
    .rdata_o (older_rd)
  );

  assign lastr = (NW'(rr_q) == side - NW'(1));
  assign lastc = (NW'(cc_q) == side - NW'(1));
  assign rv    = {rr_q >= CW'(2), lastr && (rr_q != '0), lastr};
  assign cv    = {cc_q >= CW'(2), lastc && (cc_q != '0), lastc};
  assign c_inc = NW'(cc_q) + NW'(1);
  assign r_inc = NW'(rr_q) + NW'(1);

  always_comb begin
    pend_new = '0;
    sel_rs   = '0;
    sel_cs   = '0;
    pend_clr = pend_q;
    for (int rs = 0; rs < 3; rs++) begin
      for (int cs = 0; cs < 3; cs++) begin
        pend_new[(2-rs)*3 + (2-cs)] = rv[rs] && cv[cs];
        if (pend_q[(2-rs)*3 + (2-cs)]) begin
          sel_rs = 2'(rs);
          sel_cs = 2'(cs);
        end
      end
    end
    pend_clr[(2-sel_rs)*3 + (2-sel_cs)] = 1'b0;
  end

  always_comb begin
    sum_d = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if (2'(dr) <= sel_rs && 2'(dc) <= sel_cs) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_d[ch] = sum_d[ch] + SW'(g_q[dr][dc][(2-ch)*CB +: CB]);
          end
        end
      end
    end
    case ({sel_rs, sel_cs})
      4'b0000: k_d = 4'd1;
      4'b0001, 4'b0100: k_d = 4'd2;
      4'b0010, 4'b1000: k_d = 4'd3;
      4'b0101: k_d = 4'd4;
      4'b0110, 4'b1001: k_d = 4'd6;
      4'b1010: k_d = 4'd9;
      default: k_d = 4'd1;
    endcase
  end

  assign div_ctl.en = (st_q == ST_MUL);
  assign div_ctl.k  = k_q;

  etba_div #(.CHANNEL_BITS(CB)) u_div (
    .clk_i (clk_i),
    .ctl_i (div_ctl),
    .sum_i (sum_q),
    .avg_o (avg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      size_q      <= SIZE_RESET;
      row_q       <= '0;
      col_q       <= '0;
      cw_q        <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == ST_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            st_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cw_q[5:3] <= cw_q[2:0];
          cw_q[0]   <= cur_q;
          cw_q[1]   <= newer_rd;
          cw_q[2]   <= older_rd;
          pend_q    <= pend_new;
          if (!cfg_we_i) begin
            if (c_inc >= side) begin
              col_q <= '0;
              row_q <= (r_inc >= side) ? '0 : CW'(r_inc);
            end else begin
              col_q <= CW'(c_inc);
              row_q <= rr_q;
            end
          end
          st_q <= (pend_new != '0) ? ST_SUM : ST_IDLE;
        end
        ST_SUM: begin
          pend_q <= pend_clr;
          st_q   <= ST_MUL;
        end
        ST_MUL: begin
          st_q <= ST_OUT;
        end
        ST_OUT: begin
          if (slot_free) begin
            st_q <= (pend_q != '0) ? ST_SUM : ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
        row_q  <= '0;
        col_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= cur_in;
      rr_q  <= eff_r;
      cc_q  <= eff_c;
    end
    if (st_q == ST_LOAD) begin
      g_q[0][0] <= cur_q;
      g_q[1][0] <= newer_rd;
      g_q[2][0] <= older_rd;
      for (int dr = 0; dr < 3; dr++) begin
        g_q[dr][1] <= cw_q[dr];
        g_q[dr][2] <= cw_q[3 + dr];
      end
    end
    if (st_q == ST_SUM) begin
      sum_q  <= sum_d;
      k_q    <= k_d;
      orow_q <= rr_q - CW'(sel_rs);
      ocol_q <= cc_q - CW'(sel_cs);
      last_q <= (pend_clr == '0);
    end
    if (st_q == ST_OUT && slot_free) begin
      out_q.out_row   <= POS_W'(orow_q);
      out_q.out_col   <= POS_W'(ocol_q);
      out_q.avg_red   <= FIELD_W'(avg[0]);
      out_q.avg_green <= FIELD_W'(avg[1]);
      out_q.avg_blue  <= FIELD_W'(avg[2]);
      out_q.run_end   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_q;

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (st_q == ST_LOAD))
    else $error("accepted pixel did not go to line store write-back");

  a_sum_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SUM) |-> (pend_q != '0))
    else $error("sum step with no window pending");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (st_q == ST_IDLE))
    else $error("input taken outside idle");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (NW'(col_q) < side))
    else $error("column counter beyond image side");

endmodule
